// ===== src/cra_pkg.sv =====
package cra_pkg;

    localparam int NUM_REGS        = 7;
    localparam int REG_IDX_W       = 3;
    localparam int PADDR_W         = 5;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_DIR_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_DIR_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_DIR_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_POINT_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_POINT_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_POINT_Z = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_THREE_D_MODE = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RAD_ZERO  = 2'd1;
    localparam logic [1:0] ST_AXIS_ZERO = 2'd2;

    // scaling limits ahead of the dot products
    localparam int AXIS_LIMIT_BITS = 16;
    localparam int DIFF_LIMIT_BITS = 28;

    // the largest normalized magnitude of each nonzero vector sits in [2^30, 2^31)
    localparam int NORM_MSB        = 30;
    localparam int SQ_N            = 32;
    localparam int NUM_VEC         = 2;

    localparam int Q_DEPTH         = 8;
    localparam int Q_AW            = 3;
    localparam int Q_CW            = 4;

    typedef struct packed {
        logic [2:0][31:0] dir;
        logic [2:0][31:0] pt;
        logic             mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic       axis_valid;
    } t_side;

    typedef struct packed {
        logic [2:0][63:0] v;
        logic [2:0][31:0] a;
        t_side            side;
    } t_qent;

    function automatic logic [5:0] lead_pos64(input logic [63:0] x);
        logic [5:0] pos;
        pos = '0;
        for (int k = 0; k < 64; k++) begin
            if (x[k]) begin
                pos = 6'(k);
            end
        end
        return pos;
    endfunction

endpackage

// ===== src/cra_front.sv =====
module cra_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0][31:0] i_centre,
    input  cra_pkg::t_cfg    i_cfg,
    output logic             o_push,
    output cra_pkg::t_qent   o_entry
);
    import cra_pkg::*;

    logic               r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [32:0] r1_d [3];
    logic signed [28:0] r2_d [3];
    logic signed [28:0] r3_d [3];
    logic signed [28:0] r4_d [3];
    logic signed [16:0] r2_a [3];
    logic signed [16:0] r3_a [3];
    logic signed [16:0] r4_a [3];
    logic               r2_az, r3_az, r4_az, r5_az;
    logic signed [33:0] r3_aa [3];
    logic signed [45:0] r3_ad [3];
    logic signed [35:0] r4_aa;
    logic signed [47:0] r4_ad;
    logic signed [63:0] r5_pd [3];
    logic signed [63:0] r5_pa [3];

    logic [32:0]        s2_dm [3];
    logic [28:0]        s2_dq [3];
    logic [32:0]        s2_dor;
    logic [5:0]         s2_dpos, s2_dsh;
    logic [31:0]        s2_am [3];
    logic [16:0]        s2_aq [3];
    logic [31:0]        s2_aor;
    logic [5:0]         s2_apos, s2_ash;

    logic signed [63:0] s5_v [3];
    logic               s5_vz;
    logic [1:0]         s5_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // scale the offset and the axis down by a common shift each
    always_comb begin
        s2_dor = '0;
        s2_aor = '0;
        for (int i = 0; i < 3; i++) begin
            s2_dm[i] = r1_d[i][32] ? 33'(-r1_d[i]) : 33'(r1_d[i]);
            s2_am[i] = i_cfg.dir[i][31] ? 32'(-i_cfg.dir[i]) : i_cfg.dir[i];
            s2_dor   = s2_dor | s2_dm[i];
            s2_aor   = s2_aor | s2_am[i];
        end
        s2_dpos = lead_pos64(64'(s2_dor));
        s2_apos = lead_pos64(64'(s2_aor));
        s2_dsh  = (s2_dpos >= 6'(DIFF_LIMIT_BITS)) ? s2_dpos - 6'(DIFF_LIMIT_BITS - 1) : 6'd0;
        s2_ash  = (s2_apos >= 6'(AXIS_LIMIT_BITS)) ? s2_apos - 6'(AXIS_LIMIT_BITS - 1) : 6'd0;
        for (int i = 0; i < 3; i++) begin
            s2_dq[i] = 29'(s2_dm[i] >> s2_dsh);
            s2_aq[i] = 17'(s2_am[i] >> s2_ash);
        end
    end

    always_comb begin
        s5_vz = 1'b1;
        for (int i = 0; i < 3; i++) begin
            s5_v[i] = r5_pd[i] - r5_pa[i];
            if (s5_v[i] != 64'sd0) begin
                s5_vz = 1'b0;
            end
        end
        if (r5_az) begin
            s5_status = ST_AXIS_ZERO;
        end else if (s5_vz) begin
            s5_status = ST_RAD_ZERO;
        end else begin
            s5_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_d[i]  <= $signed({i_centre[i][31], i_centre[i]})
                      - $signed({i_cfg.pt[i][31], i_cfg.pt[i]});
            r2_d[i]  <= r1_d[i][32] ? -$signed(s2_dq[i]) : $signed(s2_dq[i]);
            r2_a[i]  <= i_cfg.dir[i][31] ? -$signed(s2_aq[i]) : $signed(s2_aq[i]);
            r3_aa[i] <= r2_a[i] * r2_a[i];
            r3_ad[i] <= r2_a[i] * r2_d[i];
            r3_d[i]  <= r2_d[i];
            r3_a[i]  <= r2_a[i];
            r4_d[i]  <= r3_d[i];
            r4_a[i]  <= r3_a[i];
            r5_pd[i] <= r4_d[i] * r4_aa;
            r5_pa[i] <= r4_ad * r4_a[i];
        end
        r2_az <= (s2_aor == 32'd0);
        r3_az <= r2_az;
        r4_az <= r3_az;
        r5_az <= r4_az;
        r4_aa <= 36'(r3_aa[0]) + 36'(r3_aa[1]) + 36'(r3_aa[2]);
        r4_ad <= 48'(r3_ad[0]) + 48'(r3_ad[1]) + 48'(r3_ad[2]);
    end

    assign o_push = r5_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_entry.v[i] = s5_v[i];
        end
        o_entry.a               = i_cfg.dir;
        o_entry.side.status     = s5_status;
        o_entry.side.axis_valid = i_cfg.mode && (s5_status == ST_OK);
    end

endmodule

// ===== src/cra_queue.sv =====
module cra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cra_pkg::t_qent i_entry,
    output logic           o_valid,
    output cra_pkg::t_qent o_entry
);
    import cra_pkg::*;

    t_qent            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_CW-1:0]  r_count;
    logic [Q_CW-1:0]  n_count;

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    // drain one word every cycle the queue is not empty
    always_comb begin
        n_count = r_count;
        if (i_push && !o_valid) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_valid) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue overflow");

endmodule

// ===== src/cra_norm.sv =====
module cra_norm #(
    parameter int UNIT_FRAC_BITS = 30
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [cra_pkg::NUM_VEC-1:0][2:0][63:0]   i_u,
    input  cra_pkg::t_side                           i_side,
    output logic                                     o_valid,
    output logic [cra_pkg::NUM_VEC-1:0][2:0][31:0]   o_q,
    output cra_pkg::t_side                           o_side
);
    import cra_pkg::*;

    localparam int QB = UNIT_FRAC_BITS + 1;
    localparam int NW = 32 + UNIT_FRAC_BITS;

    typedef logic [NUM_VEC-1:0][2:0][63:0] t_mag;
    typedef logic [NUM_VEC-1:0][2:0][30:0] t_mv;
    typedef logic [NUM_VEC-1:0][2:0]       t_nv;
    typedef logic [NUM_VEC-1:0][63:0]      t_wv;
    typedef logic [NUM_VEC-1:0][2:0][31:0] t_rv;
    typedef logic [NUM_VEC-1:0][2:0][QB-1:0] t_qv;
    typedef logic [NUM_VEC-1:0][31:0]      t_nvec;

    logic    r_a_v, r_b_v, r_c_v, r_d_v;
    t_side   r_a_side, r_b_side, r_c_side, r_d_side;
    t_nv     r_a_neg, r_b_neg, r_c_neg, r_d_neg;
    t_mag    r_a_mag, r_b_mag;
    logic [NUM_VEC-1:0][5:0] r_b_pos;
    t_mv     r_c_m, r_d_m;
    logic [NUM_VEC-1:0][2:0][61:0] r_d_sq;

    logic    r_sqv  [SQ_N+1];
    t_side   r_sqs  [SQ_N+1];
    t_nv     r_sqn  [SQ_N+1];
    t_mv     r_sqm  [SQ_N+1];
    t_wv     r_sqx  [SQ_N+1];
    t_wv     r_sqr  [SQ_N+1];

    logic [NUM_VEC-1:0][2:0][NW-1:0] f_num;

    logic    r_dvv  [QB+1];
    t_side   r_dvs  [QB+1];
    t_nv     r_dvneg[QB+1];
    t_rv     r_dvrem[QB+1];
    t_qv     r_dvlow[QB+1];
    t_qv     r_dvq  [QB+1];
    t_nvec   r_dvn  [QB+1];

    t_rv     o_ext;
    logic    r_o_v;
    t_side   r_o_side;
    t_rv     r_o_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_sqv[0] <= 1'b0;
        end else begin
            r_a_v    <= i_valid;
            r_b_v    <= r_a_v;
            r_c_v    <= r_b_v;
            r_d_v    <= r_c_v;
            r_sqv[0] <= r_d_v;
        end
    end

    // magnitudes, common leading one, normalize, square, sum
    always_ff @(posedge i_clk) begin
        r_a_side   <= i_side;
        r_b_side   <= r_a_side;
        r_c_side   <= r_b_side;
        r_d_side   <= r_c_side;
        r_sqs[0]   <= r_d_side;
        r_b_neg    <= r_a_neg;
        r_c_neg    <= r_b_neg;
        r_d_neg    <= r_c_neg;
        r_sqn[0]   <= r_d_neg;
        r_b_mag    <= r_a_mag;
        r_d_m      <= r_c_m;
        r_sqm[0]   <= r_d_m;
        for (int j = 0; j < NUM_VEC; j++) begin
            r_b_pos[j] <= lead_pos64(r_a_mag[j][0] | r_a_mag[j][1] | r_a_mag[j][2]);
            r_sqx[0][j] <= 64'(r_d_sq[j][0]) + 64'(r_d_sq[j][1]) + 64'(r_d_sq[j][2]);
            r_sqr[0][j] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_a_neg[j][i] <= i_u[j][i][63];
                r_a_mag[j][i] <= i_u[j][i][63] ? 64'(-i_u[j][i]) : i_u[j][i];
                if (r_b_pos[j] >= 6'(NORM_MSB)) begin
                    r_c_m[j][i] <= 31'(r_b_mag[j][i] >> (r_b_pos[j] - 6'(NORM_MSB)));
                end else begin
                    r_c_m[j][i] <= 31'(r_b_mag[j][i] << (6'(NORM_MSB) - r_b_pos[j]));
                end
                r_d_sq[j][i] <= r_c_m[j][i] * r_c_m[j][i];
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (2 * (SQ_N - 1 - s));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[s+1] <= 1'b0;
            end else begin
                r_sqv[s+1] <= r_sqv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sqs[s+1] <= r_sqs[s];
            r_sqn[s+1] <= r_sqn[s];
            r_sqm[s+1] <= r_sqm[s];
            for (int j = 0; j < NUM_VEC; j++) begin
                if (r_sqx[s][j] >= r_sqr[s][j] + BIT) begin
                    r_sqx[s+1][j] <= r_sqx[s][j] - (r_sqr[s][j] + BIT);
                    r_sqr[s+1][j] <= (r_sqr[s][j] >> 1) + BIT;
                end else begin
                    r_sqx[s+1][j] <= r_sqx[s][j];
                    r_sqr[s+1][j] <= r_sqr[s][j] >> 1;
                end
            end
        end
    end

    // rounded dividend: m * 2^frac + n/2
    always_comb begin
        for (int j = 0; j < NUM_VEC; j++) begin
            for (int i = 0; i < 3; i++) begin
                f_num[j][i] = NW'({r_sqm[SQ_N][j][i], {UNIT_FRAC_BITS{1'b0}}})
                            + NW'(r_sqr[SQ_N][j][31:1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else begin
            r_dvv[0] <= r_sqv[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvs[0]   <= r_sqs[SQ_N];
        r_dvneg[0] <= r_sqn[SQ_N];
        r_dvq[0]   <= '0;
        for (int j = 0; j < NUM_VEC; j++) begin
            r_dvn[0][j] <= r_sqr[SQ_N][j][31:0];
            for (int i = 0; i < 3; i++) begin
                r_dvrem[0][j][i] <= {1'b0, f_num[j][i][NW-1:QB]};
                r_dvlow[0][j][i] <= f_num[j][i][QB-1:0];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = 0; s < QB; s++) begin : g_div
        logic [NUM_VEC-1:0][2:0][32:0] d_t;
        logic [NUM_VEC-1:0][2:0]       d_ge;

        always_comb begin
            for (int j = 0; j < NUM_VEC; j++) begin
                for (int i = 0; i < 3; i++) begin
                    d_t[j][i]  = {r_dvrem[s][j][i], r_dvlow[s][j][i][QB-1-s]};
                    d_ge[j][i] = (d_t[j][i] >= {1'b0, r_dvn[s][j]});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[s+1] <= 1'b0;
            end else begin
                r_dvv[s+1] <= r_dvv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dvs[s+1]   <= r_dvs[s];
            r_dvneg[s+1] <= r_dvneg[s];
            r_dvlow[s+1] <= r_dvlow[s];
            r_dvn[s+1]   <= r_dvn[s];
            for (int j = 0; j < NUM_VEC; j++) begin
                for (int i = 0; i < 3; i++) begin
                    if (d_ge[j][i]) begin
                        r_dvrem[s+1][j][i] <= 32'(d_t[j][i] - {1'b0, r_dvn[s][j]});
                    end else begin
                        r_dvrem[s+1][j][i] <= d_t[j][i][31:0];
                    end
                    r_dvq[s+1][j][i] <= {r_dvq[s][j][i][QB-2:0], d_ge[j][i]};
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_VEC; j++) begin
            for (int i = 0; i < 3; i++) begin
                o_ext[j][i] = 32'(r_dvq[QB][j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_dvv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_side <= r_dvs[QB];
        for (int j = 0; j < NUM_VEC; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_o_q[j][i] <= r_dvneg[QB][j][i] ? 32'(-o_ext[j][i]) : o_ext[j][i];
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_side  = r_o_side;
    assign o_q     = r_o_q;

endmodule

// ===== src/cylindrical_radial_axis.sv =====
// Projects each element centre onto the configured axis line and returns the unit radial
// vector (Q2.30) from the foot of the projection to the centre, plus the unit axis in 3-D
// mode, or a status code for a zero axis or a centre on the axis. One word is taken per
// clock: start is honored whenever busy is low, and busy stays low under a steady stream.
// Each result appears on o_strobe for one cycle, after passing the front stages, the queue,
// the 32-stage square root and the one-bit-per-stage divider in the normalizer; results
// leave in the order the words arrived and the receiver cannot stall them. Configuration
// must be written only while no word is in flight.
module cylindrical_radial_axis #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int UNIT_FRAC_BITS  = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 i_centre_x,
    input  logic [31:0]                 i_centre_y,
    input  logic [31:0]                 i_centre_z,
    output logic                        o_strobe,
    output logic [31:0]                 o_radial_x,
    output logic [31:0]                 o_radial_y,
    output logic [31:0]                 o_radial_z,
    output logic [31:0]                 o_axis_unit_x,
    output logic [31:0]                 o_axis_unit_y,
    output logic [31:0]                 o_axis_unit_z,
    output logic                        o_axis_unit_valid,
    output logic [1:0]                  o_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cra_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cra_pkg::*;

    logic [2:0][31:0]         r_dir;
    logic [2:0][31:0]         r_pt;
    logic                     r_mode;
    logic [Q_CW-1:0]          r_inflight;
    logic                     r_strobe;
    logic [2:0][31:0]         r_rad;
    logic [2:0][31:0]         r_ax;
    logic                     r_axv;
    logic [1:0]               r_status;

    logic                     accept;
    logic                     wr_en;
    logic [REG_IDX_W-1:0]     reg_idx;
    t_cfg                     cfg;
    logic                     push;
    t_qent                    push_entry;
    logic                     pop;
    t_qent                    head;
    logic [NUM_VEC-1:0][2:0][63:0] norm_u;
    logic                     norm_v;
    logic [NUM_VEC-1:0][2:0][31:0] norm_q;
    t_side                    norm_side;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= {32'(1) << COORD_FRAC_BITS, 32'd0, 32'd0};
            r_pt   <= '0;
            r_mode <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_AXIS_DIR_X:   r_dir[0] <= pwdata;
                REG_AXIS_DIR_Y:   r_dir[1] <= pwdata;
                REG_AXIS_DIR_Z:   r_dir[2] <= pwdata;
                REG_AXIS_POINT_X: r_pt[0]  <= pwdata;
                REG_AXIS_POINT_Y: r_pt[1]  <= pwdata;
                REG_AXIS_POINT_Z: r_pt[2]  <= pwdata;
                REG_THREE_D_MODE: r_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_AXIS_DIR_X:   prdata = r_dir[0];
            REG_AXIS_DIR_Y:   prdata = r_dir[1];
            REG_AXIS_DIR_Z:   prdata = r_dir[2];
            REG_AXIS_POINT_X: prdata = r_pt[0];
            REG_AXIS_POINT_Y: prdata = r_pt[1];
            REG_AXIS_POINT_Z: prdata = r_pt[2];
            REG_THREE_D_MODE: prdata = {31'd0, r_mode};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.dir  = r_dir;
    assign cfg.pt   = r_pt;
    assign cfg.mode = r_mode;

    // every word in the front stages holds a queue slot, so the queue never overflows
    assign busy   = (r_inflight >= Q_CW'(Q_DEPTH));
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (accept && !pop) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (!accept && pop) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    cra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_centre ({i_centre_z, i_centre_y, i_centre_x}),
        .i_cfg    (cfg),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    cra_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .o_valid  (pop),
        .o_entry  (head)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            norm_u[0][i] = head.v[i];
            norm_u[1][i] = {{32{head.a[i][31]}}, head.a[i]};
        end
    end

    cra_norm #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop),
        .i_u      (norm_u),
        .i_side   (head.side),
        .o_valid  (norm_v),
        .o_q      (norm_q),
        .o_side   (norm_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_axv    <= 1'b0;
        end else begin
            r_strobe <= norm_v;
            r_axv    <= norm_v && norm_side.axis_valid;
        end
    end

    // zero the vectors on any error, and the axis outside 3-D mode
    always_ff @(posedge i_clk) begin
        r_status <= norm_side.status;
        for (int i = 0; i < 3; i++) begin
            r_rad[i] <= (norm_side.status == ST_OK) ? norm_q[0][i] : 32'd0;
            r_ax[i]  <= norm_side.axis_valid ? norm_q[1][i] : 32'd0;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_radial_x        = r_rad[0];
    assign o_radial_y        = r_rad[1];
    assign o_radial_z        = r_rad[2];
    assign o_axis_unit_x     = r_ax[0];
    assign o_axis_unit_y     = r_ax[1];
    assign o_axis_unit_z     = r_ax[2];
    assign o_axis_unit_valid = r_axv;
    assign o_status          = r_status;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= Q_CW'(Q_DEPTH))
        else $error("in-flight count beyond queue depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |->
            (o_radial_x == 32'd0) && (o_radial_y == 32'd0) && (o_radial_z == 32'd0)
            && (o_axis_unit_x == 32'd0) && !o_axis_unit_valid)
        else $error("vector fields not cleared on error");

    a_axv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_axis_unit_valid |-> o_strobe && (o_status == ST_OK))
        else $error("axis valid without good result");

endmodule
